[src/bsr_pkg.sv]
// shared types and constants of the bmp 24-bit to rgb565 stream converter
// no dependencies
`timescale 1ns / 1ps

package bsr_pkg;

    // result kinds
    localparam logic [1:0] KIND_PIXEL   = 2'd0;
    localparam logic [1:0] KIND_HDR_OK  = 2'd1;
    localparam logic [1:0] KIND_HDR_BAD = 2'd2;

    // header layout, byte positions in the file
    localparam logic [5:0] POS_SIG_LO   = 6'd0;
    localparam logic [5:0] POS_SIG_HI   = 6'd1;
    localparam logic [5:0] POS_OFFSET   = 6'd10;
    localparam logic [5:0] POS_WIDTH    = 6'd18;
    localparam logic [5:0] POS_HEIGHT   = 6'd22;
    localparam logic [5:0] POS_PLANES   = 6'd26;
    localparam logic [5:0] POS_PLANES_H = 6'd27;
    localparam logic [5:0] POS_DEPTH    = 6'd28;
    localparam logic [5:0] POS_DEPTH_H  = 6'd29;
    localparam logic [5:0] POS_COMPR    = 6'd30;
    localparam logic [5:0] POS_HDR_LAST = 6'd33;
    localparam logic [31:0] HDR_LEN     = 32'd34;

    // expected header values
    localparam logic [7:0] SIG_LO     = 8'h42;
    localparam logic [7:0] SIG_HI     = 8'h4D;
    localparam logic [7:0] NUM_PLANES = 8'd1;
    localparam logic [7:0] BIT_DEPTH  = 8'd24;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pixel;
        logic [11:0] image_width;
        logic [11:0] image_height;
        logic        last_pixel;
    } t_out_item;

endpackage

[src/bsr_ifs.sv]
// valid/ready channel interfaces for the byte input and the result output
// depends on bsr_pkg
`timescale 1ns / 1ps

interface bsr_in_if;
    import bsr_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bsr_out_if;
    import bsr_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/bsr_in_reg.sv]
// input register stage: holds one byte request until the parser takes it
// depends on bsr_pkg, bsr_ifs
`timescale 1ns / 1ps

module bsr_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bsr_in_if.sink            i_bytes,
    input  logic              i_take,
    output logic              o_valid,
    output bsr_pkg::t_in_item o_item
);
    import bsr_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign i_bytes.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_bytes.ready) begin
            r_valid <= i_bytes.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bytes.valid && i_bytes.ready) begin
            r_item <= i_bytes.data;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[src/bsr_core.sv]
// header parser and pixel packer: parser state plus one-byte step logic
// depends on bsr_pkg
`timescale 1ns / 1ps

module bsr_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  bsr_pkg::t_in_item  i_item,
    input  logic               i_out_free,
    output logic               o_take,
    output logic               o_res_valid,
    output bsr_pkg::t_out_item o_res
);
    import bsr_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXEL,
        PH_PAD,
        PH_DONE
    } t_phase;

    t_phase        r_phase,  c_phase,  n_phase;
    logic [31:0]   r_pos,    c_pos,    n_pos;
    logic [31:0]   r_offset, c_offset, n_offset;
    logic [31:0]   r_width,  c_width,  n_width;
    logic [31:0]   r_height, c_height, n_height;
    logic          r_hdr_ok, c_hdr_ok, n_hdr_ok;
    logic [RW-1:0] r_row,    c_row,    n_row;
    logic [CW-1:0] r_col,    c_col,    n_col;
    logic [1:0]    r_bip,    c_bip,    n_bip;
    logic [1:0]    r_pad,    c_pad,    n_pad;
    logic [15:0]   r_hold,   c_hold,   n_hold;

    logic [7:0]    b;
    logic [5:0]    hpos;
    logic [1:0]    lane;
    logic          dims_ok;
    logic          ok_final;
    logic          emit;
    logic [CW-1:0] col_inc;
    logic [RW-1:0] row_inc;
    t_out_item     res;

    assign b    = i_item.data_byte;
    assign hpos = c_pos[5:0];
    // the offset, width and height fields each start two bytes into a 4-byte word
    assign lane = c_pos[1:0] - 2'd2;

    // a file start byte sees the parser as just after reset
    always_comb begin
        if (i_item.file_start) begin
            c_phase  = PH_HEADER;
            c_pos    = '0;
            c_offset = '0;
            c_width  = '0;
            c_height = '0;
            c_hdr_ok = 1'b1;
            c_row    = '0;
            c_col    = '0;
            c_bip    = '0;
            c_pad    = '0;
            c_hold   = '0;
        end else begin
            c_phase  = r_phase;
            c_pos    = r_pos;
            c_offset = r_offset;
            c_width  = r_width;
            c_height = r_height;
            c_hdr_ok = r_hdr_ok;
            c_row    = r_row;
            c_col    = r_col;
            c_bip    = r_bip;
            c_pad    = r_pad;
            c_hold   = r_hold;
        end
    end

    assign dims_ok = (c_width  >= 32'd1) && (c_width  <= 32'(MAX_WIDTH)) &&
                     (c_height >= 32'd1) && (c_height <= 32'(MAX_HEIGHT));
    assign ok_final = c_hdr_ok && (b == 8'd0) && dims_ok;
    assign col_inc  = c_col + 1'b1;
    assign row_inc  = c_row + 1'b1;

    always_comb begin
        n_phase  = c_phase;
        n_pos    = (c_pos == '1) ? c_pos : c_pos + 32'd1;
        n_offset = c_offset;
        n_width  = c_width;
        n_height = c_height;
        n_hdr_ok = c_hdr_ok;
        n_row    = c_row;
        n_col    = c_col;
        n_bip    = c_bip;
        n_pad    = c_pad;
        n_hold   = c_hold;
        emit     = 1'b0;
        res      = '0;

        unique case (c_phase)
            PH_HEADER: begin
                if (hpos == POS_SIG_LO) begin
                    if (b != SIG_LO) n_hdr_ok = 1'b0;
                end else if (hpos == POS_SIG_HI) begin
                    if (b != SIG_HI) n_hdr_ok = 1'b0;
                end else if (hpos >= POS_OFFSET && hpos < POS_OFFSET + 6'd4) begin
                    n_offset[lane*8 +: 8] = b;
                end else if (hpos >= POS_WIDTH && hpos < POS_WIDTH + 6'd4) begin
                    n_width[lane*8 +: 8] = b;
                end else if (hpos >= POS_HEIGHT && hpos < POS_HEIGHT + 6'd4) begin
                    n_height[lane*8 +: 8] = b;
                end else if (hpos == POS_PLANES) begin
                    if (b != NUM_PLANES) n_hdr_ok = 1'b0;
                end else if (hpos == POS_DEPTH) begin
                    if (b != BIT_DEPTH) n_hdr_ok = 1'b0;
                end else if (hpos == POS_PLANES_H || hpos == POS_DEPTH_H ||
                             (hpos >= POS_COMPR && hpos <= POS_HDR_LAST)) begin
                    if (b != 8'd0) n_hdr_ok = 1'b0;
                end

                if (hpos == POS_HDR_LAST) begin
                    emit = 1'b1;
                    if (ok_final) begin
                        res.kind         = KIND_HDR_OK;
                        res.image_width  = c_width[11:0];
                        res.image_height = c_height[11:0];
                        n_phase = (c_offset > HDR_LEN) ? PH_SKIP : PH_PIXEL;
                    end else begin
                        res.kind = KIND_HDR_BAD;
                        n_phase  = PH_DONE;
                    end
                end
            end
            PH_SKIP: begin
                if ({1'b0, c_pos} + 33'd1 >= {1'b0, c_offset}) n_phase = PH_PIXEL;
            end
            PH_PIXEL: begin
                if (c_bip == 2'd0) begin
                    n_hold = {8'd0, b};
                    n_bip  = 2'd1;
                end else if (c_bip == 2'd1) begin
                    n_hold = {b, c_hold[7:0]};
                    n_bip  = 2'd2;
                end else begin
                    emit      = 1'b1;
                    res.kind  = KIND_PIXEL;
                    res.pixel = {b[7:3], c_hold[15:10], c_hold[7:3]};
                    n_bip     = 2'd0;
                    if (col_inc >= c_width[CW-1:0]) begin
                        n_col = '0;
                        if (row_inc >= c_height[RW-1:0]) begin
                            res.last_pixel = 1'b1;
                            n_phase        = PH_DONE;
                        end else begin
                            n_row = row_inc;
                            // pad per row is width mod 4 for 3-byte pixels
                            n_pad = c_width[1:0];
                            if (c_width[1:0] != 2'd0) n_phase = PH_PAD;
                        end
                    end else begin
                        n_col = col_inc;
                    end
                end
            end
            PH_PAD: begin
                n_pad = c_pad - 2'd1;
                if (c_pad == 2'd1) n_phase = PH_PIXEL;
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_take      = i_valid && (!emit || i_out_free);
    assign o_res_valid = i_valid && emit && i_out_free;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_offset <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_hdr_ok <= 1'b1;
            r_row    <= '0;
            r_col    <= '0;
            r_bip    <= '0;
            r_pad    <= '0;
            r_hold   <= '0;
        end else if (o_take) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_offset <= n_offset;
            r_width  <= n_width;
            r_height <= n_height;
            r_hdr_ok <= n_hdr_ok;
            r_row    <= n_row;
            r_col    <= n_col;
            r_bip    <= n_bip;
            r_pad    <= n_pad;
            r_hold   <= n_hold;
        end
    end

endmodule

[src/bsr_out_reg.sv]
// result register: holds one result until the downstream takes it
// depends on bsr_pkg, bsr_ifs
`timescale 1ns / 1ps

module bsr_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  bsr_pkg::t_out_item i_res,
    output logic               o_free,
    bsr_out_if.source          o_pixels
);
    import bsr_pkg::*;

    logic      r_valid;
    t_out_item r_res;

    assign o_free = !r_valid || o_pixels.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_pixels.valid = r_valid;
    assign o_pixels.data  = r_res;

endmodule

[src/bmp24_stream_to_rgb565.sv]
// top level of the bmp 24-bit file stream to rgb565 pixel converter
// depends on bsr_pkg, bsr_ifs, bsr_in_reg, bsr_core, bsr_out_reg
//
//   channel    dir  carries                                      request
//   i_bytes    in   data_byte, file_start                        one file byte
//   o_pixels   out  kind, pixel, image_width, image_height,      one result
//                   last_pixel
//
// one byte per cycle sustained while o_pixels is ready; a byte is held in the input register
// and its result, if any, is held in the output register before it shows on o_pixels
// the parser step per byte is combinational counter updates and compares, registered on take
// synchronous active-low reset clears the parser to its header state
// a held result stalls only bytes that would make a new result
`timescale 1ns / 1ps

module bmp24_stream_to_rgb565 #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsr_in_if.sink    i_bytes,
    bsr_out_if.source o_pixels
);
    import bsr_pkg::*;

    logic      in_valid;
    t_in_item  in_item;
    logic      take;
    logic      out_free;
    logic      res_valid;
    t_out_item res;

    bsr_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bytes (i_bytes),
        .i_take  (take),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    bsr_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_item      (in_item),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    bsr_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_res    (res),
        .o_free   (out_free),
        .o_pixels (o_pixels)
    );

endmodule
